/* src/ordered_key_header_table_defines.svh */
// ----------------------------------------------------------------------------
// ordered key header table assertion macros
// concurrent assertion helpers, empty when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef ORDERED_KEY_HEADER_TABLE_DEFINES_SVH
`define ORDERED_KEY_HEADER_TABLE_DEFINES_SVH

`ifndef SYNTHESIS
// property holds at every edge outside reset
`define OKHT_ASSERT_ALWAYS(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// consequent holds in the cycle after the antecedent
`define OKHT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define OKHT_ASSERT_ALWAYS(label, clk, rst, prop, msg)
`define OKHT_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

/* src/okht_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// okht_pkg
// request, response and record types shared by the key header table
// ----------------------------------------------------------------------------
package okht_pkg;

  typedef enum logic [1:0] {
    OP_FIND   = 2'd0,
    OP_PUSH   = 2'd1,
    OP_UPDATE = 2'd2,
    OP_REMOVE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE,
    S_APPLY
  } state_t;

  localparam int CountOutWidth = 7;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] lookup_key;
    logic [31:0] expiry_time;
    logic [31:0] body_length;
    logic [31:0] value_start;
  } req_t;

  typedef struct packed {
    logic [1:0]               status;
    logic                     hit;
    logic [31:0]              rec_key;
    logic [31:0]              rec_expiry;
    logic [31:0]              rec_length;
    logic [31:0]              rec_start;
    logic [CountOutWidth-1:0] entry_count;
  } rsp_t;

  typedef struct packed {
    logic [31:0] key;
    logic [31:0] expiry;
    logic [31:0] length;
    logic [31:0] start;
  } rec_t;

  // broadcast from the top level to every cell
  typedef struct packed {
    logic apply;
    logic found;
    op_t  op;
  } cell_ctl_t;

endpackage

/* src/ordered_key_header_table.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_key_header_table
// ordered record table with find, push, update-to-end and remove
// ----------------------------------------------------------------------------
// The table is a row of CAPACITY cells, each holding one record (key, expiry,
// body length, value pointer); records are kept packed at the head of the row
// in insertion order (an update moves its record to the end) and a fill count
// marks the end. In the cycle a request is accepted every cell compares the
// request key with its own key and registers a match; then, in S_APPLY, the
// matched record is collected through an OR tree, the cells write or shift
// (each cell at or past the match takes its right neighbor's record to close a
// gap), the fill count moves and the response register is loaded. req_stall is
// high in S_APPLY, and the apply step waits while an earlier response is still
// held by rsp_stall. Keys stay unique, so at most one cell matches. Unwritten
// slots are never read since only slots below the fill count can match.
// ----------------------------------------------------------------------------
`include "ordered_key_header_table_defines.svh"

module ordered_key_header_table #(
  parameter int CAPACITY = 64
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  okht_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output okht_pkg::rsp_t rsp
);

  localparam int CW = $clog2(CAPACITY + 1);

  okht_pkg::state_t    state;
  okht_pkg::state_t    state_next;
  okht_pkg::req_t      req_q;
  okht_pkg::cell_ctl_t ctl;
  okht_pkg::rec_t      new_rec;
  okht_pkg::rec_t      found_rec;
  okht_pkg::rsp_t      rsp_next;
  okht_pkg::op_t       op;

  logic [CW-1:0]       count;
  logic [CW-1:0]       count_next;
  logic                accept;
  logic                apply;
  logic                found;
  logic                full;

  logic           [CAPACITY:0]   seen;
  logic           [CAPACITY-1:0] hits;
  okht_pkg::rec_t                cell_rec [CAPACITY];
  okht_pkg::rec_t                slot_rec [CAPACITY];
  okht_pkg::rec_t                next_rec [CAPACITY];

  // request handshake: one request in flight
  assign req_stall = (state != okht_pkg::S_IDLE);
  assign accept    = req_valid && !req_stall;

  // apply cycle waits for the response register to free up
  assign apply = (state == okht_pkg::S_APPLY) && (!rsp_valid || !rsp_stall);

  assign op    = okht_pkg::op_t'(req_q.req_type);
  assign found = seen[CAPACITY];
  assign full  = (count == CW'(CAPACITY));

  assign new_rec.key    = req_q.lookup_key;
  assign new_rec.expiry = req_q.expiry_time;
  assign new_rec.length = req_q.body_length;
  assign new_rec.start  = req_q.value_start;

  assign ctl.apply = apply;
  assign ctl.found = found;
  assign ctl.op    = op;

  // match chain starts empty at the head
  assign seen[0] = 1'b0;

  // cell row
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    if (i == CAPACITY - 1) begin : g_tail
      assign next_rec[i] = '0;
    end else begin : g_link
      assign next_rec[i] = slot_rec[i+1];
    end

    okht_cell #(
      .CW    (CW),
      .INDEX (i)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .capture    (accept),
      .lookup_key (req.lookup_key),
      .ctl        (ctl),
      .count      (count),
      .new_rec    (new_rec),
      .next_rec   (next_rec[i]),
      .seen_prev  (seen[i]),
      .seen       (seen[i+1]),
      .hit        (hits[i]),
      .hit_rec    (cell_rec[i]),
      .slot_rec   (slot_rec[i])
    );
  end

  // cell_rec is zero except at a matching cell; the shift takes the full
  // neighbor record from slot_rec instead
  always_comb begin
    found_rec = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      found_rec = found_rec | cell_rec[i];
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= okht_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      okht_pkg::S_IDLE: begin
        if (accept) begin
          state_next = okht_pkg::S_APPLY;
        end
      end
      okht_pkg::S_APPLY: begin
        if (apply) begin
          state_next = okht_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = okht_pkg::S_IDLE;
      end
    endcase
  end

  // request register
  always_ff @(posedge clk) begin
    if (accept) begin
      req_q <= req;
    end
  end

  // fill count and response contents
  always_comb begin
    count_next           = count;
    rsp_next             = '0;
    rsp_next.status      = okht_pkg::ST_MISS;
    rsp_next.hit         = found;
    unique case (op)
      okht_pkg::OP_FIND: begin
        if (found) begin
          rsp_next.status     = okht_pkg::ST_OK;
          rsp_next.rec_key    = found_rec.key;
          rsp_next.rec_expiry = found_rec.expiry;
          rsp_next.rec_length = found_rec.length;
          rsp_next.rec_start  = found_rec.start;
        end
      end
      okht_pkg::OP_PUSH: begin
        if (found || !full) begin
          rsp_next.status     = okht_pkg::ST_OK;
          rsp_next.rec_key    = new_rec.key;
          rsp_next.rec_expiry = new_rec.expiry;
          rsp_next.rec_length = new_rec.length;
          rsp_next.rec_start  = new_rec.start;
          if (!found) begin
            count_next = count + CW'(1);
          end
        end else begin
          rsp_next.status = okht_pkg::ST_FULL;
        end
      end
      okht_pkg::OP_UPDATE: begin
        if (found) begin
          rsp_next.status     = okht_pkg::ST_OK;
          rsp_next.rec_key    = new_rec.key;
          rsp_next.rec_expiry = new_rec.expiry;
          rsp_next.rec_length = new_rec.length;
          rsp_next.rec_start  = new_rec.start;
        end
      end
      okht_pkg::OP_REMOVE: begin
        if (found) begin
          // removed record as it stood before the gap closes
          rsp_next.status     = okht_pkg::ST_OK;
          rsp_next.rec_key    = new_rec.key;
          rsp_next.rec_expiry = found_rec.expiry;
          rsp_next.rec_length = found_rec.length;
          rsp_next.rec_start  = found_rec.start;
          count_next          = count - CW'(1);
        end
      end
      default: begin
        rsp_next.status = okht_pkg::ST_MISS;
      end
    endcase
    rsp_next.entry_count = okht_pkg::CountOutWidth'(count_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (apply) begin
      count <= count_next;
    end
  end

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (apply) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (apply) begin
      rsp <= rsp_next;
    end
  end

  // checks
  `OKHT_ASSERT_ALWAYS(a_count_range, clk, rst, count <= CW'(CAPACITY), "fill count overflow")
  `OKHT_ASSERT_ALWAYS(a_unique_match, clk, rst, (state != okht_pkg::S_APPLY) || $onehot0(hits), "several cells match")
  `OKHT_ASSERT_NEXT(a_remove_count, clk, rst, apply && op == okht_pkg::OP_REMOVE && found, count == $past(count) - CW'(1), "remove did not drop count")
  `OKHT_ASSERT_NEXT(a_accept_apply, clk, rst, accept, state == okht_pkg::S_APPLY && req_stall, "request not held for apply")

endmodule

/* src/okht_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// okht_cell
// one table slot: holds a record, matches the key, shifts toward the head
// ----------------------------------------------------------------------------
module okht_cell #(
  parameter int CW    = 7,
  parameter int INDEX = 0
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               capture,
  input  logic [31:0]        lookup_key,
  input  okht_pkg::cell_ctl_t ctl,
  input  logic [CW-1:0]      count,
  input  okht_pkg::rec_t     new_rec,
  input  okht_pkg::rec_t     next_rec,
  input  logic               seen_prev,
  output logic               seen,
  output logic               hit,
  output okht_pkg::rec_t     hit_rec,
  output okht_pkg::rec_t     slot_rec
);

  localparam logic [CW-1:0] Idx   = CW'(INDEX);
  localparam logic [CW-1:0] IdxP1 = CW'(INDEX + 1);

  okht_pkg::rec_t rec;
  okht_pkg::rec_t rec_next;
  logic           valid;

  assign valid    = Idx < count;
  assign seen     = seen_prev | hit;
  assign hit_rec  = hit ? rec : '0;
  assign slot_rec = rec;

  always_ff @(posedge clk) begin
    if (rst) begin
      hit <= 1'b0;
    end else if (capture) begin
      hit <= valid && (rec.key == lookup_key);
    end
  end

  always_comb begin
    rec_next = rec;
    if (ctl.apply) begin
      unique case (ctl.op)
        okht_pkg::OP_PUSH: begin
          // rewrite in place on a hit, append at the fill mark on a miss
          if (ctl.found && hit) begin
            rec_next = new_rec;
          end else if (!ctl.found && Idx == count) begin
            rec_next = new_rec;
          end
        end
        okht_pkg::OP_UPDATE: begin
          if (ctl.found) begin
            if (IdxP1 == count) begin
              rec_next = new_rec;
            end else if (seen && IdxP1 < count) begin
              rec_next = next_rec;
            end
          end
        end
        okht_pkg::OP_REMOVE: begin
          if (ctl.found && seen && IdxP1 < count) begin
            rec_next = next_rec;
          end
        end
        default: begin
          rec_next = rec;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    rec <= rec_next;
  end

endmodule

/* tb/ordered_key_header_table_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_key_header_table_checker
// watches both channels, keeps a shadow record table and checks each response
// ----------------------------------------------------------------------------
module ordered_key_header_table_checker #(
  parameter int CAPACITY = 64
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  input  logic           req_stall,
  input  okht_pkg::req_t req,
  input  logic           rsp_valid,
  input  logic           rsp_stall,
  input  okht_pkg::rsp_t rsp,
  output int             fail_count,
  output int             pending
);
  import okht_pkg::*;

  rec_t stored_rec [CAPACITY];
  int   stored_count;
  rsp_t expected_rsp_q [$];

  // apply one request to the shadow table and return its response
  function automatic rsp_t apply_request(req_t r);
    rsp_t o;
    rec_t fresh;
    rec_t found_rec;
    op_t  op;
    int   pos;
    int   i;
    o = '0;
    found_rec = '0;
    op = op_t'(r.req_type);
    fresh = {r.lookup_key, r.expiry_time, r.body_length, r.value_start};
    // lowest matching index wins
    pos = stored_count;
    for (i = stored_count - 1; i >= 0; i--) begin
      if (stored_rec[i].key == r.lookup_key) pos = i;
    end
    if (pos == stored_count) begin
      if (op != OP_PUSH) begin
        o.status = ST_MISS;
      end else if (stored_count >= CAPACITY) begin
        o.status = ST_FULL;
      end else begin
        stored_rec[stored_count] = fresh;
        stored_count++;
        o.status = ST_OK;
        found_rec = fresh;
      end
    end else begin
      o.status = ST_OK;
      o.hit = 1'b1;
      case (op)
        OP_FIND: begin
          found_rec = stored_rec[pos];
        end
        OP_PUSH: begin
          stored_rec[pos] = fresh;
          found_rec = fresh;
        end
        OP_UPDATE: begin
          for (i = pos; i < stored_count - 1; i++) stored_rec[i] = stored_rec[i + 1];
          stored_rec[stored_count - 1] = fresh;
          found_rec = fresh;
        end
        default: begin
          found_rec = stored_rec[pos];
          for (i = pos; i < stored_count - 1; i++) stored_rec[i] = stored_rec[i + 1];
          stored_count--;
        end
      endcase
    end
    {o.rec_key, o.rec_expiry, o.rec_length, o.rec_start} = found_rec;
    o.entry_count = CountOutWidth'(stored_count);
    return o;
  endfunction

  always @(posedge clk) begin : monitor
    rsp_t  want;
    string diff;
    if (rst) begin
      stored_count = 0;
      expected_rsp_q.delete();
      fail_count = 0;
    end else begin
      // responses first, a request taken at this edge cannot answer yet
      if (rsp_valid && !rsp_stall) begin
        if (expected_rsp_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: response with none outstanding: st %0d hit %0b key %h cnt %0d",
                     $time, rsp.status, rsp.hit, rsp.rec_key, rsp.entry_count);
        end else begin
          want = expected_rsp_q.pop_front();
          diff = "";
          if (rsp.status !== want.status) diff = {diff, " status"};
          if (rsp.hit !== want.hit) diff = {diff, " hit"};
          if (rsp.rec_key !== want.rec_key) diff = {diff, " rec_key"};
          if (rsp.rec_expiry !== want.rec_expiry) diff = {diff, " rec_expiry"};
          if (rsp.rec_length !== want.rec_length) diff = {diff, " rec_length"};
          if (rsp.rec_start !== want.rec_start) diff = {diff, " rec_start"};
          if (rsp.entry_count !== want.entry_count) diff = {diff, " entry_count"};
          if (diff != "") begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("%0t: response mismatch in%s", $time, diff);
              $display("  expected st %0d hit %0b key %h exp %h len %h ptr %h cnt %0d",
                       want.status, want.hit, want.rec_key, want.rec_expiry,
                       want.rec_length, want.rec_start, want.entry_count);
              $display("  actual   st %0d hit %0b key %h exp %h len %h ptr %h cnt %0d",
                       rsp.status, rsp.hit, rsp.rec_key, rsp.rec_expiry,
                       rsp.rec_length, rsp.rec_start, rsp.entry_count);
            end
          end
        end
      end
      if (req_valid && !req_stall) expected_rsp_q.push_back(apply_request(req));
    end
    pending = expected_rsp_q.size();
  end

endmodule

/* tb/ordered_key_header_table_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_key_header_table_tb
// directed and random find, push, update and remove requests against the
// record table, with bursty requests and a stalling response side
// ----------------------------------------------------------------------------
module ordered_key_header_table_tb;
  import okht_pkg::*;

  localparam int CAPACITY = 64;
  // enough distinct keys to overfill the table
  localparam int POOL_SIZE = 80;
  localparam logic [31:0] KEY_A = 32'h1234_5678;
  localparam logic [31:0] KEY_B = 32'hA5A5_5A5A;
  localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

  // response side stall behavior, switched per segment
  typedef enum {STALL_NONE, STALL_SOME, STALL_HEAVY} stall_mode_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  int fail_count;
  int pending;

  logic [31:0] key_pool [POOL_SIZE];
  int          burst_left = 0;
  int          stall_left = 0;
  stall_mode_t stall_mode = STALL_NONE;

  // 8 ns period
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  ordered_key_header_table #(
    .CAPACITY(CAPACITY)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  // predicts every response and counts failures
  ordered_key_header_table_checker #(
    .CAPACITY(CAPACITY)
  ) table_checker (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .req        (req),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .rsp        (rsp),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // response stall: segments of random length, each free, lightly or heavily stalled
  always @(negedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      if (stall_left == 0) begin
        stall_mode = stall_mode_t'($urandom_range(0, 2));
        stall_left = $urandom_range(4, 48);
      end
      stall_left--;
      case (stall_mode)
        STALL_NONE:  rsp_stall <= 1'b0;
        STALL_SOME:  rsp_stall <= ($urandom_range(0, 2) == 0);
        default:     rsp_stall <= (stall_left % 5 != 0);
      endcase
    end
  end

  function automatic req_t make_req(op_t op, logic [31:0] key, logic [31:0] expiry,
                                    logic [31:0] length, logic [31:0] start);
    req_t r;
    r.req_type    = op;
    r.lookup_key  = key;
    r.expiry_time = expiry;
    r.body_length = length;
    r.value_start = start;
    return r;
  endfunction

  // weighted choice of operation
  function automatic op_t pick_op(int w_find, int w_push, int w_update, int w_remove);
    int roll;
    roll = $urandom_range(0, w_find + w_push + w_update + w_remove - 1);
    if (roll < w_find) return OP_FIND;
    roll -= w_find;
    if (roll < w_push) return OP_PUSH;
    roll -= w_push;
    if (roll < w_update) return OP_UPDATE;
    return OP_REMOVE;
  endfunction

  // mostly keys from the head of the pool so hits are common, sometimes a fresh key
  function automatic logic [31:0] pick_key(int span);
    if ($urandom_range(0, 99) < 8) return $urandom();
    return key_pool[$urandom_range(0, span - 1)];
  endfunction

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send(input req_t r);
    if (burst_left == 0) begin
      // gap between bursts, sometimes followed by a long unbroken burst
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? 60 : $urandom_range(1, 12);
    end
    req_valid <= 1'b1;
    req       <= r;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    burst_left--;
    @(negedge clk);
  endtask

  task automatic send_random(input op_t op, input logic [31:0] key);
    send(make_req(op, key, $urandom(), $urandom(), $urandom()));
  endtask

  // hold requests back until every response is in
  task automatic wait_drained();
    req_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  initial begin : stimulus
    int i;
    key_pool[0] = '0;
    key_pool[1] = ALL_ONES;
    for (i = 2; i < POOL_SIZE; i++) key_pool[i] = $urandom();

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: misses on the empty table
    send(make_req(OP_FIND, '0, '0, '0, '0));
    send(make_req(OP_UPDATE, '0, ALL_ONES, ALL_ONES, ALL_ONES));
    send(make_req(OP_REMOVE, ALL_ONES, '0, '0, '0));
    // appends with extreme keys and fields
    send(make_req(OP_PUSH, '0, '0, '0, '0));
    send(make_req(OP_PUSH, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES));
    send_random(OP_PUSH, KEY_A);
    send_random(OP_PUSH, KEY_B);
    // find hits, then rewrite in place
    send(make_req(OP_FIND, '0, ALL_ONES, ALL_ONES, ALL_ONES));
    send_random(OP_FIND, ALL_ONES);
    send(make_req(OP_PUSH, ALL_ONES, '0, '0, '0));
    // update the first record, moving it to the end, then update the last one
    send(make_req(OP_UPDATE, '0, ALL_ONES, '0, ALL_ONES));
    send_random(OP_FIND, KEY_A);
    send(make_req(OP_UPDATE, '0, '0, ALL_ONES, '0));
    send_random(OP_UPDATE, 32'h0000_0005);
    // remove middle, last and first, a miss, then empty the table
    send_random(OP_REMOVE, KEY_B);
    send_random(OP_REMOVE, '0);
    send_random(OP_REMOVE, ALL_ONES);
    send_random(OP_REMOVE, 32'h0000_0005);
    send_random(OP_FIND, ALL_ONES);
    send_random(OP_REMOVE, KEY_A);
    send_random(OP_FIND, KEY_A);

    // random mix over a small key set, lots of hits
    for (i = 0; i < 150; i++) send_random(pick_op(25, 35, 20, 20), pick_key(24));

    // pause with nothing in flight before filling the table
    wait_drained();

    // more distinct keys than slots: the table ends up full
    for (i = 0; i < 70; i++) send_random(OP_PUSH, key_pool[i]);
    // full table: push misses, moves to the end and finds
    for (i = 0; i < 12; i++) begin
      send_random(OP_PUSH, $urandom());
      send_random((i % 2 == 1) ? OP_UPDATE : OP_FIND, key_pool[$urandom_range(0, 69)]);
    end

    // mostly removes until the table runs low
    for (i = 0; i < 120; i++) send_random(pick_op(20, 15, 15, 50), pick_key(POOL_SIZE));

    // final mix over a wider key set
    for (i = 0; i < 150; i++) send_random(pick_op(25, 30, 25, 20), pick_key(40));

    wait_drained();
    // trailing cycles catch any stray response
    repeat (12) @(negedge clk);

    if (fail_count == 0) begin
      $display("ordered_key_header_table_tb passed");
    end else begin
      $display("ordered_key_header_table_tb failed");
    end
    $finish;
  end

  // watchdog, far beyond the slowest correct run
  initial begin
    #2_000_000;
    $display("ordered_key_header_table_tb failed");
    $finish;
  end

endmodule
